FILE: design/rom_patch_token_scheduler_assert.svh
// Assertion macros for the ROM patch token scheduler.
`ifndef ROM_PATCH_TOKEN_SCHEDULER_ASSERT_SVH
`define ROM_PATCH_TOKEN_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RPTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RPTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rpts_pkg.sv
// Shared types and constants for the ROM patch token scheduler.
package rpts_pkg;

  localparam int RPTS_RULES       = 8;
  localparam int RPTS_BURST_WORDS = 256;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int INDEX_W = 9;
  localparam int COVER_W = 10;
  localparam int SKIP_W  = 9;
  localparam int HALF_W  = 16;

  localparam logic [31:0]        WORD_ALIGN = 32'hFFFF_FFFC;
  localparam logic [INDEX_W-1:0] INDEX_IDLE = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  rule_slot;
    logic [31:0] rule_mask;
    logic [31:0] rule_match;
    logic [31:0] rule_value;
    logic        rule_enable;
    logic [31:0] burst_addr;
    logic        killed;
  } item_t;

endpackage

FILE: design/rpts_front.sv
// Front end: accepts requests into a short in-order queue.
module rpts_front
  import rpts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t item_in,
  output logic  busy,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;

  assign busy    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign push    = start && !busy;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/rpts_rule_table.sv
// Patch rule table: one write port, one registered read port.
module rpts_rule_table
  import rpts_pkg::*;
#(
  parameter int RULES = RPTS_RULES,
  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [IW-1:0] wr_idx,
  input  logic [31:0]   wr_mask,
  input  logic [31:0]   wr_match,
  input  logic [31:0]   wr_value,
  input  logic          wr_enable,
  input  logic [IW-1:0] rd_idx,
  output logic [31:0]   rd_mask,
  output logic [31:0]   rd_match,
  output logic [31:0]   rd_value,
  output logic          rd_enable
);

  logic [31:0]      masks      [RULES];
  logic [31:0]      match_vals [RULES];
  logic [31:0]      values     [RULES];
  logic [RULES-1:0] enables;

  // contents are meaningful only once a slot is loaded; enable gates them
  always_ff @(posedge clk) begin
    if (we) begin
      masks[wr_idx]      <= wr_mask;
      match_vals[wr_idx] <= wr_match;
      values[wr_idx]     <= wr_value;
    end
    rd_mask  <= masks[rd_idx];
    rd_match <= match_vals[rd_idx];
    rd_value <= values[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enables   <= '0;
      rd_enable <= 1'b0;
    end else begin
      if (we) begin
        enables[wr_idx] <= wr_enable;
      end
      rd_enable <= enables[rd_idx];
    end
  end

endmodule

FILE: design/rpts_back.sv
// Back end: executes queued requests, walks the rule table, builds results.
module rpts_back
  import rpts_pkg::*;
#(
  parameter int RULES       = RPTS_RULES,
  parameter int BURST_WORDS = RPTS_BURST_WORDS,
  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              tbl_we,
  output logic [IW-1:0]     tbl_wr_idx,
  output logic [IW-1:0]     tbl_rd_idx,
  input  logic [31:0]       rd_mask,
  input  logic [31:0]       rd_match,
  input  logic [31:0]       rd_value,
  input  logic              rd_enable,
  output logic              result_strobe,
  output logic              hit,
  output logic [31:0]       word_addr,
  output logic [SKIP_W-1:0] skip,
  output logic [HALF_W-1:0] lead_half,
  output logic [HALF_W-1:0] trail_half,
  output logic              last_word
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_SCAN = 2'b10
  } back_state_t;

  back_state_t          state;
  logic [31:0]          burst_base;
  logic                 high_first;
  logic                 suppressed;
  logic [COVER_W-1:0]   covered;
  logic [INDEX_W-1:0]   word_index;
  logic [IW-1:0]        scan_idx;
  logic                 cmp_valid;
  logic                 cmp_last;
  logic [31:0]          cur_addr;

  logic                 idle;
  logic                 slot_ok;
  logic                 step_go;
  logic [31:0]          step_addr;
  logic                 rule_hit;
  logic                 scan_done;
  logic                 finish;
  logic                 fin_hit;
  logic [COVER_W-1:0]   half_pos;
  logic [COVER_W-1:0]   skip_full;

  assign idle       = (state == BK_IDLE);
  assign q_pop      = idle && q_valid;
  assign slot_ok    = (32'(q_item.rule_slot) < RULES);
  assign tbl_we     = q_pop && (q_item.operation == OP_LOAD) && slot_ok;
  assign tbl_wr_idx = IW'(q_item.rule_slot);
  assign tbl_rd_idx = scan_idx;

  assign step_go   = q_pop && (q_item.operation == OP_STEP)
                     && (32'(word_index) < BURST_WORDS);
  assign step_addr = burst_base + {21'd0, word_index, 2'b00};

  // compare the entry read in the previous cycle
  assign rule_hit  = cmp_valid && rd_enable
                     && ((cur_addr & rd_mask) == (rd_match & rd_mask));
  assign scan_done = (state == BK_SCAN) && (rule_hit || (cmp_valid && cmp_last));
  assign finish    = (step_go && suppressed) || scan_done;
  assign fin_hit   = scan_done && rule_hit;

  assign half_pos  = {word_index, 1'b0};
  assign skip_full = half_pos - covered;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      burst_base    <= '0;
      high_first    <= 1'b1;
      suppressed    <= 1'b1;
      covered       <= '0;
      word_index    <= INDEX_IDLE;
      cmp_valid     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= finish;
      if (finish) begin
        word_index <= word_index + 1'b1;
        if (fin_hit) begin
          covered <= half_pos + COVER_W'(2);
        end
      end
      unique case (state)
        BK_IDLE: begin
          if (q_pop) begin
            unique case (q_item.operation)
              OP_START: begin
                burst_base <= q_item.burst_addr & WORD_ALIGN;
                high_first <= !q_item.burst_addr[1];
                suppressed <= q_item.killed;
                covered    <= '0;
                word_index <= '0;
              end
              OP_STEP: begin
                if (step_go && !suppressed) begin
                  state     <= BK_SCAN;
                  cmp_valid <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        BK_SCAN: begin
          if (scan_done) begin
            state <= BK_IDLE;
          end else begin
            cmp_valid <= 1'b1;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (idle) begin
      scan_idx <= '0;
      cur_addr <= step_addr;
      cmp_last <= 1'b0;
    end else if (!scan_done) begin
      cmp_last <= (scan_idx == IW'(RULES - 1));
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit       <= fin_hit;
      word_addr <= idle ? step_addr : cur_addr;
      last_word <= (32'(word_index) == BURST_WORDS - 1);
      if (fin_hit) begin
        skip       <= skip_full[SKIP_W-1:0];
        lead_half  <= high_first ? rd_value[31:16] : rd_value[15:0];
        trail_half <= high_first ? rd_value[15:0] : rd_value[31:16];
      end else begin
        skip       <= '0;
        lead_half  <= '0;
        trail_half <= '0;
      end
    end
  end

endmodule

FILE: design/rom_patch_token_scheduler.sv
// ROM patch token scheduler, top level.
//
// Requests enter on start/busy: one is taken at a clock edge with start high
// and busy low. The operation port picks load rule slot, start burst or step
// one word; the other input ports carry that request's operands.
// Requests queue two deep ahead of the execution side; busy is high while the
// queue is full.
// Load, start and unknown requests produce no result. A step in a killed
// burst gives a miss result without walking the table; otherwise the
// rule table is walked one slot per cycle through its registered read port,
// lowest slot first, stopping at the first match or after the last slot.
// A step past the end of the burst is dropped. A result appears in the
// cycle after its step finishes, held for exactly one cycle with
// result_strobe high; the receiver cannot stall it.
// Reset clears all rule enables, ends any burst (overrides suppressed) and
// empties the queue; rule contents stay as they were.
`include "rom_patch_token_scheduler_assert.svh"
module rom_patch_token_scheduler
  import rpts_pkg::*;
#(
  parameter int RULES       = RPTS_RULES,
  parameter int BURST_WORDS = RPTS_BURST_WORDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [2:0]        rule_slot,
  input  logic [31:0]       rule_mask,
  input  logic [31:0]       rule_match,
  input  logic [31:0]       rule_value,
  input  logic              rule_enable,
  input  logic [31:0]       burst_addr,
  input  logic              killed,
  output logic              result_strobe,
  output logic              hit,
  output logic [31:0]       word_addr,
  output logic [SKIP_W-1:0] skip,
  output logic [HALF_W-1:0] lead_half,
  output logic [HALF_W-1:0] trail_half,
  output logic              last_word
);

  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;

  item_t         in_item;
  item_t         q_item;
  logic          q_valid;
  logic          q_pop;
  logic          tbl_we;
  logic [IW-1:0] tbl_wr_idx;
  logic [IW-1:0] tbl_rd_idx;
  logic [31:0]   rd_mask;
  logic [31:0]   rd_match;
  logic [31:0]   rd_value;
  logic          rd_enable;

  always_comb begin
    in_item.operation   = operation;
    in_item.rule_slot   = rule_slot;
    in_item.rule_mask   = rule_mask;
    in_item.rule_match  = rule_match;
    in_item.rule_value  = rule_value;
    in_item.rule_enable = rule_enable;
    in_item.burst_addr  = burst_addr;
    in_item.killed      = killed;
  end

  rpts_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item_in (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rpts_rule_table #(
    .RULES (RULES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .we        (tbl_we),
    .wr_idx    (tbl_wr_idx),
    .wr_mask   (q_item.rule_mask),
    .wr_match  (q_item.rule_match),
    .wr_value  (q_item.rule_value),
    .wr_enable (q_item.rule_enable),
    .rd_idx    (tbl_rd_idx),
    .rd_mask   (rd_mask),
    .rd_match  (rd_match),
    .rd_value  (rd_value),
    .rd_enable (rd_enable)
  );

  rpts_back #(
    .RULES       (RULES),
    .BURST_WORDS (BURST_WORDS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .tbl_we        (tbl_we),
    .tbl_wr_idx    (tbl_wr_idx),
    .tbl_rd_idx    (tbl_rd_idx),
    .rd_mask       (rd_mask),
    .rd_match      (rd_match),
    .rd_value      (rd_value),
    .rd_enable     (rd_enable),
    .result_strobe (result_strobe),
    .hit           (hit),
    .word_addr     (word_addr),
    .skip          (skip),
    .lead_half     (lead_half),
    .trail_half    (trail_half),
    .last_word     (last_word)
  );

  `RPTS_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")
  `RPTS_ASSERT_IMPL(a_miss_zero, result_strobe && !hit,
    skip == '0 && lead_half == '0 && trail_half == '0, "miss result not zeroed")
  `RPTS_ASSERT_NEXT(a_fill_busy, start && !busy && !q_pop && q_valid, busy,
    "queue filled without raising busy")

endmodule
